FILE: hw/rtl/itra_pkg.sv
// Shared types, constants and the digit glyph function for the integer to
// radix ASCII converter. No dependencies.
`default_nettype none

package itra_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_DIGITS_DEF = 32;

  // Quotient bits resolved per divider cycle.
  localparam int STEP_BITS = 4;

  localparam logic [4:0] RADIX_MIN = 5'd2;
  localparam logic [4:0] RADIX_MAX = 5'd16;
  localparam logic [4:0] RADIX_DEC = 5'd10;

  localparam logic [3:0] DIGIT_TEN   = 4'd10;
  localparam logic [7:0] GLYPH_ZERO  = 8'h30;
  localparam logic [7:0] GLYPH_ALPHA = 8'h61;
  localparam logic [7:0] GLYPH_MINUS = 8'h2d;
  localparam logic [7:0] GLYPH_NONE  = 8'h00;

  typedef struct packed {
    logic load;   // take a new magnitude and start the first digit
    logic start;  // start the next digit on the quotient held
  } div_cmd_t;

  typedef struct packed {
    logic       done;    // remainder and quotient valid this cycle
    logic       q_zero;  // quotient held is zero
    logic [3:0] digit;   // remainder of the last division
  } div_sts_t;

  function automatic logic [7:0] glyph(input logic [3:0] d);
    logic [7:0] g;
    if (d < DIGIT_TEN) begin
      g = GLYPH_ZERO + {4'b0000, d};
    end else begin
      g = GLYPH_ALPHA + {4'b0000, d - DIGIT_TEN};
    end
    return g;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/itra_divider.sv
// Iterative divider by a narrow base, STEP_BITS quotient bits per cycle.
// Depends on itra_pkg.
`default_nettype none

module itra_divider #(
  parameter int VALUE_BITS = itra_pkg::VALUE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire itra_pkg::div_cmd_t cmd,
  input  wire logic [VALUE_BITS-1:0] magnitude,
  input  wire logic [4:0]         base,
  output itra_pkg::div_sts_t      sts
);

  localparam int ITERS  = (VALUE_BITS + itra_pkg::STEP_BITS - 1) / itra_pkg::STEP_BITS;
  localparam int QW     = ITERS * itra_pkg::STEP_BITS;
  localparam int ITER_W = $clog2(ITERS);

  logic [QW-1:0]     q_r, q_nxt;
  logic [4:0]        r_r, r_nxt;
  logic [ITER_W-1:0] cnt_r;
  logic              busy_r, done_r;

  // Combinational step of restoring division: STEP_BITS shift and subtract steps.
  always_comb begin
    logic [4:0] t;
    q_nxt = q_r;
    r_nxt = r_r;
    for (int k = 0; k < itra_pkg::STEP_BITS; k++) begin
      t     = {r_nxt[3:0], q_nxt[QW-1]};
      q_nxt = {q_nxt[QW-2:0], 1'b0};
      if (t >= base) begin
        r_nxt    = t - base;
        q_nxt[0] = 1'b1;
      end else begin
        r_nxt = t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      q_r    <= '0;
      r_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.load || cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        r_r    <= '0;
        if (cmd.load) begin
          q_r <= QW'(magnitude);
        end
      end else if (busy_r) begin
        q_r   <= q_nxt;
        r_r   <= r_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ITER_W'(ITERS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.done   = done_r;
  assign sts.q_zero = (q_r == '0);
  assign sts.digit  = r_r[3:0];

endmodule

`default_nettype wire

FILE: hw/rtl/integer_to_radix_ascii_core.sv
// Sequence: each digit takes one pass through the shared divider, and the first character
// of a value is loaded only after all of its digits are stored; a bad base shows without
// any division.
// Output: each digit character is a memory read, then an output load; a new value
// is taken only after the last character is loaded.
// Reset: rst_n is synchronous, active low; no clearing pass is needed.
`default_nettype none

module integer_to_radix_ascii_core #(
  parameter int VALUE_BITS = itra_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = itra_pkg::MAX_DIGITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // in_tdata fields from bit 0: value[VALUE_BITS], radix[5], zero pad.
  input  wire logic [((VALUE_BITS + 5 + 7) / 8) * 8 - 1:0] in_tdata,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // out_tdata fields from bit 0: symbol[8].
  output logic [7:0] out_tdata,
  output logic      out_tlast,
  // out_tuser fields from bit 0: bad_base[1].
  output logic      out_tuser,
  output logic      out_tvalid,
  input  wire logic out_tready
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = $clog2(MAX_DIGITS);

  // The sequencer drives the divider once per digit, stores each digit,
  // then reads the store back from the most significant digit down.
  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_BAD       = 7'b0000010,
    ST_DIV       = 7'b0000100,
    ST_EMIT_SIGN = 7'b0001000,
    ST_EMIT_RD   = 7'b0010000,
    ST_EMIT_OUT  = 7'b0100000,
    ST_SPARE     = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [4:0]       base_r, base_nxt;
  logic             sign_r, sign_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_sym_r, out_sym_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_bad_r, out_bad_nxt;

  logic [VALUE_BITS-1:0] in_value;
  logic [4:0]            in_radix;
  logic                  radix_ok;
  logic                  in_neg;
  logic [VALUE_BITS-1:0] magnitude;
  logic                  in_fire;
  logic                  out_free;

  itra_pkg::div_cmd_t div_cmd;
  itra_pkg::div_sts_t div_sts;

  logic             wr_en;
  logic             rd_en;
  logic [3:0]       digit_mem [MAX_DIGITS];
  logic [3:0]       rd_data_r;
  logic [CNT_W-1:0] cnt_after;

  assign in_value = in_tdata[VALUE_BITS-1:0];
  assign in_radix = in_tdata[VALUE_BITS+4:VALUE_BITS];
  assign radix_ok = (in_radix >= itra_pkg::RADIX_MIN) && (in_radix <= itra_pkg::RADIX_MAX);
  assign in_neg   = in_value[VALUE_BITS-1];
  // The most negative value wraps to itself, which is its correct magnitude.
  assign magnitude = in_neg ? (~in_value + VALUE_BITS'(1)) : in_value;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  // The output register may take a new word when empty or being drained.
  assign out_free  = !out_valid_r || out_tready;

  assign wr_en     = (state_r == ST_DIV) && div_sts.done && (cnt_r < CNT_W'(MAX_DIGITS));
  assign rd_en     = (state_r == ST_EMIT_RD);
  assign cnt_after = wr_en ? cnt_r + 1'b1 : cnt_r;

  itra_divider #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (div_cmd),
    .magnitude(magnitude),
    .base     (base_r),
    .sts      (div_sts)
  );

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    sign_nxt      = sign_r;
    cnt_nxt       = cnt_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_sym_nxt   = out_sym_r;
    out_last_nxt  = out_last_r;
    out_bad_nxt   = out_bad_r;
    div_cmd       = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (radix_ok) begin
            base_nxt     = in_radix;
            sign_nxt     = in_neg && (in_radix == itra_pkg::RADIX_DEC);
            cnt_nxt      = '0;
            div_cmd.load = 1'b1;
            state_nxt    = ST_DIV;
          end else begin
            state_nxt = ST_BAD;
          end
        end
      end
      ST_BAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = itra_pkg::GLYPH_NONE;
          out_last_nxt  = 1'b1;
          out_bad_nxt   = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          cnt_nxt = cnt_after;
          if (!div_sts.q_zero) begin
            div_cmd.start = 1'b1;
          end else begin
            // At least one digit is always stored, so cnt_after is nonzero.
            rd_idx_nxt = IDX_W'(cnt_after - 1'b1);
            state_nxt  = sign_r ? ST_EMIT_SIGN : ST_EMIT_RD;
          end
        end
      end
      ST_EMIT_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = itra_pkg::GLYPH_MINUS;
          out_last_nxt  = 1'b0;
          out_bad_nxt   = 1'b0;
          state_nxt     = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = itra_pkg::glyph(rd_data_r);
          out_last_nxt  = (rd_idx_r == '0);
          out_bad_nxt   = 1'b0;
          if (rd_idx_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r - 1'b1;
            state_nxt  = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r     <= base_nxt;
    sign_r     <= sign_nxt;
    rd_idx_r   <= rd_idx_nxt;
    out_sym_r  <= out_sym_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  // Digit store: least significant digit at entry zero.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      digit_mem[cnt_r[IDX_W-1:0]] <= div_sts.digit;
    end
    if (rd_en) begin
      rd_data_r <= digit_mem[rd_idx_r];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sym_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_bad_r;

  // A word flagged for a bad base is always the last of its conversion.
  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("bad-base word without last");

  // The divider only reports a result while the sequencer waits for it.
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> state_r == ST_DIV)
    else $error("divider result outside division phase");

  // The store is never written past its depth.
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> cnt_r < CNT_W'(MAX_DIGITS))
    else $error("digit store overflow");

  // Read back only touches entries written by this conversion.
  a_rd_written: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> CNT_W'(rd_idx_r) < cnt_r)
    else $error("read of unwritten digit");

  // A stalled output word is held.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word dropped while stalled");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for integer_to_radix_ascii_core: it streams signed values
// with a base and checks every character word against an in-bench predictor.
// Depends on itra_pkg and the core RTL only.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VBITS      = 32;
  localparam int IN_W       = ((VBITS + 5 + 7) / 8) * 8;
  localparam int RAND_ITEMS = 125;
  localparam int STALL_MAX  = 4000;  // cycles with no handshake on either side
  localparam int DRAIN      = 400;   // longer than one full 32-digit conversion
  localparam int HOLD_LEN   = 600;   // the long back-pressure stretch on the output

  // One character word as the core should present it.
  typedef struct {
    logic [7:0] symbol;
    logic       last;
    logic       bad_base;
  } char_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic [IN_W-1:0] in_tdata = '0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [7:0]      out_tdata;
  logic            out_tlast;
  logic            out_tuser;
  logic            out_tvalid;
  logic            out_tready = 1'b0;

  logic [IN_W-1:0] pending_words[$];
  char_word_t      expected_chars[$];
  int              errors = 0;

  integer_to_radix_ascii_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),   // value[32], radix[5], zero pad
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),  // symbol[8]
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),  // bad_base[1]
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Works out the characters of one accepted word and queues them. Digits come from
  // truncating division of the magnitude; only base ten gets a leading minus sign.
  task automatic predict_text(input logic [IN_W-1:0] word);
    logic [VBITS-1:0] value;
    logic [4:0]       radix;
    logic [VBITS-1:0] mag;
    logic [3:0]       digits[0:31];
    logic [3:0]       d;
    int               cnt;
    bit               minus;
    char_word_t       cw;
    value = word[VBITS-1:0];
    radix = word[VBITS+4:VBITS];
    if (radix < itra_pkg::RADIX_MIN || radix > itra_pkg::RADIX_MAX) begin
      cw.symbol = itra_pkg::GLYPH_NONE;
      cw.last = 1'b1;
      cw.bad_base = 1'b1;
      expected_chars.push_back(cw);
      return;
    end
    // The most negative value negates to itself, which is its correct magnitude.
    mag = value[VBITS-1] ? (~value + 1'b1) : value;
    cnt = 0;
    do begin
      digits[cnt] = 4'(mag % radix);
      cnt++;
      mag = mag / radix;
    end while (mag != 0);
    minus = value[VBITS-1] && (radix == itra_pkg::RADIX_DEC);
    cw.bad_base = 1'b0;
    if (minus) begin
      cw.symbol = itra_pkg::GLYPH_MINUS;
      cw.last = 1'b0;
      expected_chars.push_back(cw);
    end
    for (int i = cnt - 1; i >= 0; i--) begin
      d = digits[i];
      cw.symbol = (d < itra_pkg::DIGIT_TEN) ? itra_pkg::GLYPH_ZERO + 8'(d)
                : itra_pkg::GLYPH_ALPHA + 8'(d - itra_pkg::DIGIT_TEN);
      cw.last = (i == 0);
      expected_chars.push_back(cw);
    end
  endtask

  function automatic logic [IN_W-1:0] pack_word(input logic [31:0] value, input logic [4:0] radix);
    return {{(IN_W - VBITS - 5){1'b0}}, radix, value};
  endfunction

  // Random values: mostly valid bases, with a spread of magnitudes and signs.
  function automatic logic [IN_W-1:0] random_word();
    logic [31:0] value;
    logic [4:0]  radix;
    int          pick;
    int          r;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2: value = $urandom;
      3, 4:    value = $urandom_range(0, 1000);
      5, 6:    value = -$urandom_range(1, 1000);
      7: begin
        r = $urandom_range(0, 3);
        value = (r == 0) ? 32'h8000_0000 : (r == 1) ? 32'h7fff_ffff :
                (r == 2) ? 32'hffff_ffff : 32'h0;
      end
      default: begin
        value = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) value = -value;
      end
    endcase
    if ($urandom_range(0, 9) == 0) begin
      // Bad bases: 0, 1 and 17 to 31.
      r = $urandom_range(0, 16);
      radix = (r < 2) ? 5'(r) : 5'(r + 15);
    end else begin
      radix = 5'($urandom_range(2, 16));
    end
    return pack_word(value, radix);
  endfunction

  // Driver: offers the pending words in order, with random gaps except in a gap-free window.
  int accepted_words = 0;

  always @(posedge clk) begin
    bit gap;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_text(in_tdata);
        accepted_words++;
      end
      if (!in_tvalid || in_tready) begin
        gap = (accepted_words >= 40 && accepted_words < 90) ? 1'b0
            : ($urandom_range(0, 99) < 13);
        if (pending_words.size() != 0 && !gap) begin
          in_tdata  <= pending_words.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each character word against the oldest expectation and throttles
  // out_tready, including one long hold-off that backs the core up into its input.
  int  chars_seen = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    char_word_t cw;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        chars_seen++;
        if (expected_chars.size() == 0) begin
          $error("unexpected word: symbol %h last %b bad_base %b",
                 out_tdata, out_tlast, out_tuser);
          errors++;
        end else begin
          cw = expected_chars.pop_front();
          if (out_tdata !== cw.symbol) begin
            $error("symbol: expected %h, got %h", cw.symbol, out_tdata);
            errors++;
          end
          if (out_tlast !== cw.last) begin
            $error("last: expected %b, got %b", cw.last, out_tlast);
            errors++;
          end
          if (out_tuser !== cw.bad_base) begin
            $error("bad_base: expected %b, got %b", cw.bad_base, out_tuser);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && chars_seen >= 300) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
        out_tready <= 1'b0;
      end else if (chars_seen >= 100 && chars_seen < 250) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= 13);
      end
    end
  end

  // Watchdog: ends the run if neither side moves a word for too long.
  int stall_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_MAX) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Stimulus: directed corner cases first, then the random part.
  initial begin
    // Zero in a few bases, and the extremes of the value range.
    pending_words.push_back(pack_word(32'd0, 5'd10));
    pending_words.push_back(pack_word(32'd0, 5'd2));
    pending_words.push_back(pack_word(32'd0, 5'd16));
    pending_words.push_back(pack_word(32'h8000_0000, 5'd2));
    pending_words.push_back(pack_word(32'h8000_0000, 5'd10));
    pending_words.push_back(pack_word(32'h8000_0000, 5'd16));
    pending_words.push_back(pack_word(32'h8000_0000, 5'd8));
    pending_words.push_back(pack_word(32'h7fff_ffff, 5'd2));
    pending_words.push_back(pack_word(32'h7fff_ffff, 5'd10));
    pending_words.push_back(pack_word(32'h7fff_ffff, 5'd16));
    // Minus one: signed in base ten, bare magnitude elsewhere.
    pending_words.push_back(pack_word(32'hffff_ffff, 5'd10));
    pending_words.push_back(pack_word(32'hffff_ffff, 5'd16));
    pending_words.push_back(pack_word(32'hffff_ffff, 5'd2));
    pending_words.push_back(pack_word(-32'sd42, 5'd8));
    // Hex letters and the odd bases.
    pending_words.push_back(pack_word(32'd255, 5'd16));
    pending_words.push_back(pack_word(32'h00ab_cdef, 5'd16));
    pending_words.push_back(pack_word(32'd12345, 5'd3));
    pending_words.push_back(pack_word(32'd12345, 5'd5));
    pending_words.push_back(pack_word(32'd12345, 5'd7));
    pending_words.push_back(pack_word(32'd12345, 5'd13));
    pending_words.push_back(pack_word(-32'sd12345, 5'd15));
    // Bad bases on both sides of the valid range.
    pending_words.push_back(pack_word(32'd77, 5'd0));
    pending_words.push_back(pack_word(32'hffff_ffff, 5'd1));
    pending_words.push_back(pack_word(32'd5, 5'd17));
    pending_words.push_back(pack_word(32'h8000_0000, 5'd31));
    for (int i = 0; i < RAND_ITEMS; i++) begin
      pending_words.push_back(random_word());
    end

    // Sampled on the falling edge so every queue and handshake has settled.
    do begin
      @(negedge clk);
    end while (pending_words.size() != 0 || in_tvalid || expected_chars.size() != 0);
    repeat (DRAIN) @(negedge clk);

    if (errors == 0 && expected_chars.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
